// ===== rtl/sprite_quad_batcher_unit_macros.svh =====
// Assertion helpers for the sprite quad batcher.
`ifndef SPRITE_QUAD_BATCHER_UNIT_MACROS_SVH
`define SPRITE_QUAD_BATCHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SQB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqb assertion failed");
`define SQB_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sqb assertion failed");
`else
`define SQB_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SQB_ASSERT_NEXT(label, clk, ante, cons)
`endif

`endif

// ===== rtl/sqb_pkg.sv =====
package sqb_pkg;

  localparam int SPRITE_CAPACITY_DEF = 1024;
  localparam int SLOT_DEPTH_DEF      = 16;
  localparam int QUEUE_DEPTH         = 2;

  localparam int MAX_SPRITES_W = 11;
  localparam int MAX_SLOTS_W   = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 11;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPRITES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SLOTS   = 1'b1;

  localparam logic [MAX_SPRITES_W-1:0] MAX_SPRITES_RST = 11'd1024;
  localparam logic [MAX_SLOTS_W-1:0]   MAX_SLOTS_RST   = 5'd16;

  localparam logic CMD_DRAW    = 1'b0;
  localparam logic CMD_END     = 1'b1;
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam int TEX_W   = 32;
  localparam int POS_W   = 16;
  localparam int COORD_W = 17;
  localparam int SLOT_W  = 4;
  localparam int INDEX_W = 13;
  localparam int BOUND_W = 5;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;

  localparam int SLOT_LSB  = 2 * COORD_W + 2;
  localparam int INDEX_LSB = SLOT_LSB + SLOT_W;
  localparam int BOUND_LSB = INDEX_LSB + INDEX_W;
  localparam int OUT_PAD_W = OUT_DATA_W - (BOUND_LSB + BOUND_W);

  typedef struct packed {
    logic [MAX_SPRITES_W-1:0] max_sprites;
    logic [MAX_SLOTS_W-1:0]   max_slots;
  } cfg_t;

  // one classified command with the quad corners already summed
  typedef struct packed {
    logic                      is_end;
    logic [TEX_W-1:0]          tex;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
  } job_t;

endpackage

// ===== rtl/sqb_front.sv =====
module sqb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sqb_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  output sqb_pkg::job_t                   job,
  output logic                            job_valid,
  input  logic                            job_ready
);

  logic                              vld;
  logic signed [sqb_pkg::POS_W-1:0]  px, py, pw, ph;
  logic signed [sqb_pkg::COORD_W-1:0] x0, y0;

  assign px = s_tdata[47:32];
  assign py = s_tdata[63:48];
  assign pw = s_tdata[79:64];
  assign ph = s_tdata[95:80];
  assign x0 = sqb_pkg::COORD_W'(px);
  assign y0 = sqb_pkg::COORD_W'(py);

  assign s_tready  = !vld || job_ready;
  assign job_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tready) begin
      vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      job.is_end <= (s_tuser == sqb_pkg::CMD_END);
      job.tex    <= s_tdata[31:0];
      job.x0     <= x0;
      job.y0     <= y0;
      // 17-bit sums cannot overflow
      job.x1     <= x0 + sqb_pkg::COORD_W'(pw);
      job.y1     <= y0 + sqb_pkg::COORD_W'(ph);
    end
  end

endmodule

// ===== rtl/sqb_queue.sv =====
module sqb_queue #(
  parameter int DEPTH = sqb_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  sqb_pkg::job_t in_job,
  input  logic          in_valid,
  output logic          in_ready,
  output sqb_pkg::job_t out_job,
  output logic          out_valid,
  input  logic          out_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sqb_pkg::job_t  mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           push, pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

endmodule

// ===== rtl/sqb_back.sv =====
module sqb_back #(
  parameter int SPRITE_CAPACITY = sqb_pkg::SPRITE_CAPACITY_DEF,
  parameter int SLOT_DEPTH      = sqb_pkg::SLOT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sqb_pkg::cfg_t                  cfg,
  input  sqb_pkg::job_t                  job,
  input  logic                           job_valid,
  output logic                           job_ready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sqb_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);

  localparam int SCW = $clog2(SPRITE_CAPACITY + 1);
  localparam int SMW = (SCW > sqb_pkg::MAX_SPRITES_W) ? SCW : sqb_pkg::MAX_SPRITES_W;
  localparam int SNW = $clog2(SLOT_DEPTH + 1);
  localparam int SLW = (SNW > sqb_pkg::MAX_SLOTS_W) ? SNW : sqb_pkg::MAX_SLOTS_W;
  localparam int SIW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_SEARCH  = 3'd2;
  localparam logic [2:0] ST_RESOLVE = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0]                state;
  sqb_pkg::job_t             cur;
  logic [SCW-1:0]            sprite_count;
  logic [SNW-1:0]            slot_count;
  logic [sqb_pkg::TEX_W-1:0] slot_tab [SLOT_DEPTH];
  logic [SLOT_DEPTH-1:0]     hits, hit_now;
  logic [SIW-1:0]            enc, slot_sel;
  logic [1:0]                corner;

  logic [SMW-1:0] ms, lim_s;
  logic [SLW-1:0] mt, lim_t;
  logic           need_flush, load_ok, load;
  logic [sqb_pkg::INDEX_W-1:0] cnt13, idx_now;
  logic           cu, cv;

  logic                              out_kind, out_last, out_u, out_v;
  logic signed [sqb_pkg::COORD_W-1:0] out_x, out_y;
  logic [sqb_pkg::SLOT_W-1:0]        out_slot;
  logic [sqb_pkg::INDEX_W-1:0]       out_idx;
  logic [sqb_pkg::BOUND_W-1:0]       out_bound;

  // clamp limits: zero acts as one, above the storage acts as the storage
  always_comb begin
    ms = SMW'(cfg.max_sprites);
    if (ms == '0) begin
      lim_s = SMW'(1);
    end else if (ms > SMW'(SPRITE_CAPACITY)) begin
      lim_s = SMW'(SPRITE_CAPACITY);
    end else begin
      lim_s = ms;
    end
    mt = SLW'(cfg.max_slots);
    if (mt == '0) begin
      lim_t = SLW'(1);
    end else if (mt > SLW'(SLOT_DEPTH)) begin
      lim_t = SLW'(SLOT_DEPTH);
    end else begin
      lim_t = mt;
    end
  end

  assign need_flush = cur.is_end || (SMW'(sprite_count) >= lim_s) ||
                      (SLW'(slot_count) >= lim_t);
  assign load_ok    = !m_tvalid || m_tready;
  assign load       = load_ok && (((state == ST_CHECK) && need_flush) ||
                                  (state == ST_EMIT));
  assign job_ready  = (state == ST_IDLE);
  assign cnt13      = sqb_pkg::INDEX_W'(sprite_count);
  assign idx_now    = (cnt13 << 2) + (cnt13 << 1);
  assign cu         = corner[0] ^ corner[1];
  assign cv         = corner[1];

  always_comb begin
    for (int i = 0; i < SLOT_DEPTH; i++) begin
      hit_now[i] = (SNW'(i) < slot_count) && (slot_tab[i] == cur.tex);
    end
  end

  // live entries are unique, so at most one hit: an OR encoder suffices
  always_comb begin
    enc = '0;
    for (int i = 0; i < SLOT_DEPTH; i++) begin
      if (hits[i]) begin
        enc = enc | SIW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sprite_count <= '0;
      slot_count   <= '0;
      corner       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!need_flush) begin
            state <= ST_SEARCH;
          end else if (load_ok) begin
            out_kind     <= sqb_pkg::KIND_FLUSH;
            out_last     <= cur.is_end;
            out_x        <= '0;
            out_y        <= '0;
            out_u        <= 1'b0;
            out_v        <= 1'b0;
            out_slot     <= '0;
            out_idx      <= idx_now;
            out_bound    <= sqb_pkg::BOUND_W'(slot_count);
            sprite_count <= '0;
            slot_count   <= '0;
            state        <= cur.is_end ? ST_IDLE : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          hits  <= hit_now;
          state <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          if (|hits) begin
            slot_sel <= enc;
          end else begin
            slot_sel                   <= SIW'(slot_count);
            slot_tab[SIW'(slot_count)] <= cur.tex;
            slot_count                 <= slot_count + 1'b1;
          end
          sprite_count <= sprite_count + 1'b1;
          corner       <= '0;
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_ok) begin
            out_kind  <= sqb_pkg::KIND_VERTEX;
            out_last  <= (corner == 2'd3);
            out_x     <= cu ? cur.x1 : cur.x0;
            out_y     <= cv ? cur.y1 : cur.y0;
            out_u     <= cu;
            out_v     <= cv;
            out_slot  <= sqb_pkg::SLOT_W'(slot_sel);
            out_idx   <= '0;
            out_bound <= '0;
            corner    <= corner + 1'b1;
            if (corner == 2'd3) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tuser = out_kind;
  assign m_tlast = out_last;
  assign m_tdata = {{sqb_pkg::OUT_PAD_W{1'b0}}, out_bound, out_idx, out_slot,
                    out_v, out_u, out_y, out_x};

endmodule

// ===== rtl/sprite_quad_batcher_unit.sv =====
// Channel  Dir  Fields (tdata low bit up)                                  tuser    tlast
// s_*      in   texture_id, pos_x, pos_y, size_w, size_h                   command  -
// m_*      out  vert_x, vert_y, tex_u, tex_v, slot, index_total,           kind     last
//               slots_bound, zero pad to 64
// cfg_*    in   write port: index 0 max_sprites, index 1 max_slots
//
// A draw word passes the sequencer in steps: fetch, limit check, slot compare,
// slot resolve, four corner words; an end word takes only fetch and limit check.
// The sequencer takes one word at a time. The front register and a 2-entry queue
// keep taking words while the sequencer is busy. Reset (rst, synchronous) clears
// counts and valids; the slot table is not cleared. Output stalls hold the
// sequencer in place.
`include "sprite_quad_batcher_unit_macros.svh"

module sprite_quad_batcher_unit #(
  parameter int SPRITE_CAPACITY = sqb_pkg::SPRITE_CAPACITY_DEF,
  parameter int SLOT_DEPTH      = sqb_pkg::SLOT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // texture_id[31:0], pos_x[47:32], pos_y[63:48], size_w[79:64], size_h[95:80]
  input  logic [sqb_pkg::IN_DATA_W-1:0]  s_tdata,
  // command
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // vert_x[16:0], vert_y[33:17], tex_u[34], tex_v[35], slot[39:36],
  // index_total[52:40], slots_bound[57:53], zero[63:58]
  output logic [sqb_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind
  output logic                           m_tuser,
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [sqb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sqb_pkg::CFG_DATA_W-1:0] cfg_data
);

  sqb_pkg::cfg_t cfg;
  sqb_pkg::job_t front_job, queue_job;
  logic          front_valid, front_ready, queue_valid, queue_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_sprites <= sqb_pkg::MAX_SPRITES_RST;
      cfg.max_slots   <= sqb_pkg::MAX_SLOTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sqb_pkg::REG_MAX_SPRITES: cfg.max_sprites <= cfg_data[sqb_pkg::MAX_SPRITES_W-1:0];
        sqb_pkg::REG_MAX_SLOTS:   cfg.max_slots   <= cfg_data[sqb_pkg::MAX_SLOTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sqb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  sqb_queue #(
    .DEPTH (sqb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_job    (front_job),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_job   (queue_job),
    .out_valid (queue_valid),
    .out_ready (queue_ready)
  );

  sqb_back #(
    .SPRITE_CAPACITY (SPRITE_CAPACITY),
    .SLOT_DEPTH      (SLOT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (queue_job),
    .job_valid (queue_valid),
    .job_ready (queue_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  logic [sqb_pkg::SLOT_W-1:0]  mon_slot;
  logic [sqb_pkg::INDEX_W-1:0] mon_idx;
  logic [sqb_pkg::BOUND_W-1:0] mon_bound;

  assign mon_slot  = m_tdata[sqb_pkg::SLOT_LSB +: sqb_pkg::SLOT_W];
  assign mon_idx   = m_tdata[sqb_pkg::INDEX_LSB +: sqb_pkg::INDEX_W];
  assign mon_bound = m_tdata[sqb_pkg::BOUND_LSB +: sqb_pkg::BOUND_W];

  `SQB_ASSERT_IMPLIES(a_vertex_no_counts, clk, rst,
    m_tvalid && m_tuser == sqb_pkg::KIND_VERTEX, mon_idx == '0 && mon_bound == '0)
  `SQB_ASSERT_IMPLIES(a_marker_shape, clk, rst,
    m_tvalid && m_tuser == sqb_pkg::KIND_FLUSH,
    mon_slot == '0 && 32'(mon_bound) <= SLOT_DEPTH)
  `SQB_ASSERT_NEXT(a_reset_idle, clk, rst, !m_tvalid && s_tready)

endmodule
